/* sv/poi_pkg.sv */
// shared types and constants of the planar odometry integrator
package poi_pkg;

    localparam int VEL_W      = 16;
    localparam int TURN_W     = 24;
    localparam int STEP_W     = 16;
    localparam int OUT_POS_W  = 40;
    localparam int HEAD_W     = 32;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 168;

    // item kinds carried on the input tuser
    localparam logic FUNC_VEL  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // cordic datapath
    localparam int CRD_W      = 34;
    localparam int ATAN_N     = 32;
    localparam int ATAN_IDX_W = 5;
    localparam logic signed [CRD_W-1:0] CORDIC_START_X = 34'sd652032874;

    localparam logic [31:0] ATAN_TABLE [ATAN_N] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    // shared multiplier and accumulator
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ROT_W      = 50;
    localparam int ROT_LO_W   = 24;
    localparam int ACC_W      = 68;
    localparam int DELTA_SH   = 42;
    localparam int DELTA_W    = ACC_W - DELTA_SH;

    typedef struct packed {
        logic [OUT_POS_W-1:0] pos_x;
        logic [OUT_POS_W-1:0] pos_y;
        logic [HEAD_W-1:0]    heading;
    } t_pose;

endpackage

/* sv/poi_cordic.sv */
// iterative rotation-mode cordic giving cosine and sine of a binary angle
module poi_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [poi_pkg::HEAD_W-1:0]          i_angle,
    output logic                                o_done,
    output logic signed [poi_pkg::CRD_W-1:0]    o_cos,
    output logic signed [poi_pkg::CRD_W-1:0]    o_sin
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_STEPS - 1);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_flip;
    logic [CNT_W-1:0]                   r_iter;
    logic signed [poi_pkg::CRD_W-1:0]   r_x;
    logic signed [poi_pkg::CRD_W-1:0]   r_y;
    logic signed [poi_pkg::CRD_W-1:0]   r_z;

    logic signed [poi_pkg::CRD_W-1:0]   n_x;
    logic signed [poi_pkg::CRD_W-1:0]   n_y;
    logic signed [poi_pkg::CRD_W-1:0]   n_z;
    logic signed [poi_pkg::CRD_W-1:0]   x_sh;
    logic signed [poi_pkg::CRD_W-1:0]   y_sh;
    logic signed [poi_pkg::CRD_W-1:0]   atan_step;
    logic                               start_flip;
    logic [poi_pkg::HEAD_W-1:0]         start_ang;

    always_comb begin
        x_sh      = r_x >>> r_iter;
        y_sh      = r_y >>> r_iter;
        atan_step = {2'b00, poi_pkg::ATAN_TABLE[poi_pkg::ATAN_IDX_W'(r_iter)]};
        if (!r_z[poi_pkg::CRD_W-1]) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_step;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_step;
        end
    end

    // second and third quadrants are folded by a half turn
    assign start_flip = i_angle[31] ^ i_angle[30];
    assign start_ang  = i_angle ^ {start_flip, 31'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_iter == LAST_ITER) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= start_flip;
            r_iter <= '0;
            r_x    <= poi_pkg::CORDIC_START_X;
            r_y    <= '0;
            r_z    <= {{2{start_ang[31]}}, start_ang};
        end else if (r_busy) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            if (r_iter != LAST_ITER) begin
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

/* sv/poi_integ.sv */
// pose state and the multiply sequence that rotates, scales and accumulates
module poi_integ #(
    parameter int POS_BITS = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [poi_pkg::CRD_W-1:0]    i_cos,
    input  logic signed [poi_pkg::CRD_W-1:0]    i_sin,
    input  logic signed [poi_pkg::VEL_W-1:0]    i_vel_x,
    input  logic signed [poi_pkg::VEL_W-1:0]    i_vel_y,
    input  logic signed [poi_pkg::TURN_W-1:0]   i_turn,
    input  logic [poi_pkg::STEP_W-1:0]          i_step_time,
    output logic                                o_done,
    output poi_pkg::t_pose                      o_pose
);

    localparam int SUM_W = ((POS_BITS > poi_pkg::DELTA_W) ? POS_BITS : poi_pkg::DELTA_W) + 1;
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [poi_pkg::ACC_W-1:0] ROUND_HALF =
        poi_pkg::ACC_W'(1) << (poi_pkg::DELTA_SH - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RX    = 4'd1;
    localparam logic [3:0] S_RY_A  = 4'd2;
    localparam logic [3:0] S_RY    = 4'd3;
    localparam logic [3:0] S_DX_HI = 4'd4;
    localparam logic [3:0] S_DX_LO = 4'd5;
    localparam logic [3:0] S_DY_HI = 4'd6;
    localparam logic [3:0] S_DY_LO = 4'd7;
    localparam logic [3:0] S_HEAD  = 4'd8;

    logic [3:0]                             r_step;
    logic                                   r_done;
    logic signed [poi_pkg::ACC_W-1:0]       r_acc;
    logic signed [poi_pkg::ROT_W-1:0]       r_rx;
    logic signed [poi_pkg::ROT_W-1:0]       r_ry;
    logic signed [POS_BITS-1:0]             r_pos_x;
    logic signed [POS_BITS-1:0]             r_pos_y;
    logic [poi_pkg::HEAD_W-1:0]             r_heading;

    logic signed [poi_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [poi_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [poi_pkg::PROD_W-1:0]      prod;
    logic signed [poi_pkg::ACC_W-1:0]       prod_ext;
    logic signed [poi_pkg::ACC_W-1:0]       acc_diff;
    logic signed [poi_pkg::ACC_W-1:0]       acc_sum;
    logic signed [poi_pkg::ACC_W-1:0]       acc_join;
    logic signed [poi_pkg::DELTA_W-1:0]     delta;
    logic signed [63:0]                     pos_x_ext;
    logic signed [63:0]                     pos_y_ext;

    function automatic logic signed [POS_BITS-1:0] sat_add(
        input logic signed [POS_BITS-1:0]         pos,
        input logic signed [poi_pkg::DELTA_W-1:0] d
    );
        logic signed [SUM_W-1:0]    sum;
        logic [SUM_W-POS_BITS:0]    top;
        sum = SUM_W'(pos) + SUM_W'(d);
        top = sum[SUM_W-1:POS_BITS-1];
        if ((&top) || !(|top)) begin
            return sum[POS_BITS-1:0];
        end else if (sum[SUM_W-1]) begin
            return POS_MIN;
        end else begin
            return POS_MAX;
        end
    endfunction

    // operand selection for the one shared multiplier
    always_comb begin
        unique case (r_step)
            S_IDLE: begin
                mul_a = i_cos;
                mul_b = poi_pkg::MUL_B_W'(i_vel_x);
            end
            S_RX: begin
                mul_a = i_sin;
                mul_b = poi_pkg::MUL_B_W'(i_vel_y);
            end
            S_RY_A: begin
                mul_a = i_sin;
                mul_b = poi_pkg::MUL_B_W'(i_vel_x);
            end
            S_RY: begin
                mul_a = i_cos;
                mul_b = poi_pkg::MUL_B_W'(i_vel_y);
            end
            S_DX_HI: begin
                mul_a = {18'd0, i_step_time};
                mul_b = r_rx[poi_pkg::ROT_W-1:poi_pkg::ROT_LO_W];
            end
            S_DX_LO: begin
                mul_a = {18'd0, i_step_time};
                mul_b = {2'b00, r_rx[poi_pkg::ROT_LO_W-1:0]};
            end
            S_DY_HI: begin
                mul_a = {18'd0, i_step_time};
                mul_b = r_ry[poi_pkg::ROT_W-1:poi_pkg::ROT_LO_W];
            end
            S_DY_LO: begin
                mul_a = {18'd0, i_step_time};
                mul_b = {2'b00, r_ry[poi_pkg::ROT_LO_W-1:0]};
            end
            S_HEAD: begin
                mul_a = {18'd0, i_step_time};
                mul_b = poi_pkg::MUL_B_W'(i_turn);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = poi_pkg::ACC_W'(prod);
    assign acc_diff = r_acc - prod_ext;
    assign acc_sum  = r_acc + prod_ext;
    // high partial product moves up by the low slice width, then round half up
    assign acc_join = (r_acc <<< poi_pkg::ROT_LO_W) + prod_ext + ROUND_HALF;
    assign delta    = r_acc[poi_pkg::ACC_W-1:poi_pkg::DELTA_SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= S_IDLE;
            r_done    <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc  <= prod_ext;
                        r_step <= S_RX;
                    end
                end
                S_RX: begin
                    r_rx   <= acc_diff[poi_pkg::ROT_W-1:0];
                    r_step <= S_RY_A;
                end
                S_RY_A: begin
                    r_acc  <= prod_ext;
                    r_step <= S_RY;
                end
                S_RY: begin
                    r_ry   <= acc_sum[poi_pkg::ROT_W-1:0];
                    r_step <= S_DX_HI;
                end
                S_DX_HI: begin
                    r_acc  <= prod_ext;
                    r_step <= S_DX_LO;
                end
                S_DX_LO: begin
                    r_acc  <= acc_join;
                    r_step <= S_DY_HI;
                end
                S_DY_HI: begin
                    r_pos_x <= sat_add(r_pos_x, delta);
                    r_acc   <= prod_ext;
                    r_step  <= S_DY_LO;
                end
                S_DY_LO: begin
                    r_acc  <= acc_join;
                    r_step <= S_HEAD;
                end
                S_HEAD: begin
                    r_pos_y   <= sat_add(r_pos_y, delta);
                    r_heading <= r_heading + prod[poi_pkg::HEAD_W-1:0];
                    r_done    <= 1'b1;
                    r_step    <= S_IDLE;
                end
                default: begin
                    r_step <= S_IDLE;
                end
            endcase
        end
    end

    assign pos_x_ext      = 64'(r_pos_x);
    assign pos_y_ext      = 64'(r_pos_y);
    assign o_done         = r_done;
    assign o_pose.pos_x   = pos_x_ext[poi_pkg::OUT_POS_W-1:0];
    assign o_pose.pos_y   = pos_y_ext[poi_pkg::OUT_POS_W-1:0];
    assign o_pose.heading = r_heading;

endmodule

/* sv/planar_odometry_integrator.sv */
// top level: item handshake, step register, velocity latch and result register
// a velocity item is latched on acceptance and the block stays ready; a tick item
// gives its result after the cordic iterations and nine steps of the shared
// multiplier; one tick at a time, the next item is taken after the tick's result
// is loaded into the output register, which waits until that register is free
// synchronous active-low reset zeroes pose and velocities, step time to 6554
module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_BITS     = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [poi_pkg::STEP_W-1:0]          i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // lin_vel_x [15:0], lin_vel_y [31:16], ang_vel [55:32]
    input  logic [poi_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // func
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // pos_x [39:0], pos_y [79:40], heading [111:80], echo_vel_x [127:112],
    // echo_vel_y [143:128], echo_ang_vel [167:144]
    output logic [poi_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CORDIC = 2'd1;
    localparam logic [1:0] S_INTEG  = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;
    localparam logic [poi_pkg::STEP_W-1:0] STEP_RESET = 16'd6554;

    logic [1:0]                             r_state;
    logic [poi_pkg::STEP_W-1:0]             r_step_time;
    logic signed [poi_pkg::VEL_W-1:0]       r_vel_x;
    logic signed [poi_pkg::VEL_W-1:0]       r_vel_y;
    logic signed [poi_pkg::TURN_W-1:0]      r_turn;
    logic                                   r_out_valid;
    logic [poi_pkg::OUT_DATA_W-1:0]         r_out_data;

    logic                                   in_fire;
    logic                                   tick_fire;
    logic                                   emit_load;
    logic                                   cordic_done;
    logic signed [poi_pkg::CRD_W-1:0]       cos_val;
    logic signed [poi_pkg::CRD_W-1:0]       sin_val;
    logic                                   integ_done;
    poi_pkg::t_pose                         pose;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign tick_fire       = in_fire && (i_s_axis_tuser == poi_pkg::FUNC_TICK);
    assign emit_load       = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);

    poi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tick_fire),
        .i_angle (pose.heading),
        .o_done  (cordic_done),
        .o_cos   (cos_val),
        .o_sin   (sin_val)
    );

    poi_integ #(
        .POS_BITS (POS_BITS)
    ) u_integ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cordic_done),
        .i_cos       (cos_val),
        .i_sin       (sin_val),
        .i_vel_x     (r_vel_x),
        .i_vel_y     (r_vel_y),
        .i_turn      (r_turn),
        .i_step_time (r_step_time),
        .o_done      (integ_done),
        .o_pose      (pose)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_time <= STEP_RESET;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_turn      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step_time <= i_cfg_wdata;
            end
            if (in_fire && (i_s_axis_tuser == poi_pkg::FUNC_VEL)) begin
                r_vel_x <= i_s_axis_tdata[15:0];
                r_vel_y <= i_s_axis_tdata[31:16];
                r_turn  <= i_s_axis_tdata[55:32];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (tick_fire) begin
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (cordic_done) begin
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (integ_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase

            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_data <= {r_turn, r_vel_y, r_vel_x, pose.heading, pose.pos_y, pose.pos_x};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
